>>> src/rgb_pixel_hash_cache_assert.svh
// Assertion macros for the colour cache; they sample on clk and stay quiet in rst.
`ifndef RGB_PIXEL_HASH_CACHE_ASSERT_SVH
`define RGB_PIXEL_HASH_CACHE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rphc: check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rphc: check failed");

`endif

>>> src/rphc_pkg.sv
`default_nettype none
package rphc_pkg;

  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int PIX_W   = 32;
  localparam int RGB_W   = 24;
  localparam int WORD_W  = RGB_W + PIX_W;
  localparam int TDATA_W = 64;
  localparam int ADDR_W  = 3;

  localparam logic [IDX_W-1:0] BLACK_SLOT = IDX_W'(0);
  localparam logic [IDX_W-1:0] WHITE_SLOT = IDX_W'(63);
  localparam logic [RGB_W-1:0] RGB_BLACK  = 24'h000000;
  localparam logic [RGB_W-1:0] RGB_WHITE  = 24'hFFFFFF;
  localparam logic [PIX_W-1:0] RESET_BLACK_PIX = 32'h0000_0000;
  localparam logic [PIX_W-1:0] RESET_WHITE_PIX = 32'h00FF_FFFF;
  localparam logic [SLOTS-1:0] VALID_SEED =
    (SLOTS'(1) << WHITE_SLOT) | (SLOTS'(1) << BLACK_SLOT);

  // Register select is paddr[2]
  localparam logic REG_BLACK = 1'b0;
  localparam logic REG_WHITE = 1'b1;

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_INSERT  = 2'd2,
    CMD_REVERSE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_RST_BLACK,
    ST_RST_WHITE,
    ST_IDLE,
    ST_DECODE,
    ST_SEED_WHITE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_valid;
    logic seed_black;
    logic seed_white;
    logic seed_reset;
    logic scan_start;
    logic scan_run;
    logic write_ins;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic quick_hit;
    logic scan_done;
  } stat_t;

  // Home slot: top two bits of red, green and blue
  function automatic logic [IDX_W-1:0] home_slot(input logic [RGB_W-1:0] rgb);
    logic [IDX_W-1:0] h;
    h = '0;
    h[5:0] = {rgb[23:22], rgb[15:14], rgb[7:6]};
    return h;
  endfunction

endpackage
`default_nettype wire

>>> src/rphc_ctrl.sv
`default_nettype none
module rphc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output logic                 out_valid,
  input  wire rphc_pkg::stat_t stat,
  output rphc_pkg::ctrl_t      ctrl
);

  rphc_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rphc_pkg::ST_RST_BLACK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      rphc_pkg::ST_RST_BLACK: begin
        ctrl.seed_black = 1'b1;
        ctrl.seed_reset = 1'b1;
        state_next      = rphc_pkg::ST_RST_WHITE;
      end
      rphc_pkg::ST_RST_WHITE: begin
        ctrl.seed_white = 1'b1;
        ctrl.seed_reset = 1'b1;
        state_next      = rphc_pkg::ST_IDLE;
      end
      rphc_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
        if (in_valid) begin
          state_next = rphc_pkg::ST_DECODE;
        end
      end
      rphc_pkg::ST_DECODE: begin
        case (stat.cmd)
          rphc_pkg::CMD_INIT: begin
            ctrl.clear_valid = 1'b1;
            ctrl.seed_black  = 1'b1;
            state_next       = rphc_pkg::ST_SEED_WHITE;
          end
          rphc_pkg::CMD_REVERSE: begin
            if (stat.quick_hit) begin
              state_next = rphc_pkg::ST_DONE;
            end else begin
              ctrl.scan_start = 1'b1;
              state_next      = rphc_pkg::ST_SCAN;
            end
          end
          default: begin
            ctrl.scan_start = 1'b1;
            state_next      = rphc_pkg::ST_SCAN;
          end
        endcase
      end
      rphc_pkg::ST_SEED_WHITE: begin
        ctrl.seed_white = 1'b1;
        state_next      = rphc_pkg::ST_DONE;
      end
      rphc_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = (stat.cmd == rphc_pkg::CMD_INSERT) ? rphc_pkg::ST_WRITE
                                                           : rphc_pkg::ST_DONE;
        end else begin
          ctrl.scan_run = 1'b1;
        end
      end
      rphc_pkg::ST_WRITE: begin
        ctrl.write_ins = 1'b1;
        state_next     = rphc_pkg::ST_DONE;
      end
      rphc_pkg::ST_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = rphc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rphc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/rphc_dp.sv
`default_nettype none
module rphc_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rphc_pkg::ctrl_t              ctrl,
  input  wire logic [rphc_pkg::TDATA_W-1:0] in_data,
  input  wire logic [rphc_pkg::PIX_W-1:0]   black_pixel,
  input  wire logic [rphc_pkg::PIX_W-1:0]   white_pixel,
  output rphc_pkg::stat_t                   stat,
  output logic [rphc_pkg::TDATA_W-1:0]      out_data
);

  localparam int IDX_W  = rphc_pkg::IDX_W;
  localparam int CNT_W  = rphc_pkg::CNT_W;
  localparam int PIX_W  = rphc_pkg::PIX_W;
  localparam int RGB_W  = rphc_pkg::RGB_W;
  localparam int WORD_W = rphc_pkg::WORD_W;
  localparam int SLOTS  = rphc_pkg::SLOTS;

  // slot store: colour in the upper bits, pixel in the lower bits
  logic [WORD_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]  valid_bits;

  rphc_pkg::cmd_t     cmd_q;
  logic [RGB_W-1:0]   rgb_q;
  logic [PIX_W-1:0]   pix_q;
  logic [IDX_W-1:0]   home_q;
  logic               quick_black;
  logic               quick_white;

  logic [IDX_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   issue_cnt;
  logic [CNT_W-1:0]   eval_cnt;
  logic               chk_vld;
  logic [IDX_W-1:0]   chk_idx;
  logic [WORD_W-1:0]  rd_word;
  logic               scan_done;
  logic               res_found;
  logic [IDX_W-1:0]   res_idx;
  logic [WORD_W-1:0]  res_word;

  logic               issue;
  logic               chk_v;
  logic [RGB_W-1:0]   chk_color;
  logic [PIX_W-1:0]   chk_pix;
  logic               is_rev;
  logic               match;
  logic               stop;
  logic [IDX_W-1:0]   sel_idx;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;

  logic               out_hit;
  logic [PIX_W-1:0]   out_pix;
  logic [RGB_W-1:0]   out_rgb;

  assign issue     = ctrl.scan_run && (issue_cnt != CNT_W'(SLOTS));
  assign chk_v     = valid_bits[chk_idx];
  assign chk_color = rd_word[WORD_W-1:PIX_W];
  assign chk_pix   = rd_word[PIX_W-1:0];
  assign is_rev    = (cmd_q == rphc_pkg::CMD_REVERSE);
  assign match     = is_rev ? (chk_v && chk_pix == pix_q) : (chk_v && chk_color == rgb_q);
  // probe stops on empty, match or full wrap; reverse search only on match or end
  assign stop      = match || (eval_cnt == CNT_W'(SLOTS - 1)) || (!is_rev && !chk_v);
  assign sel_idx   = (match || !chk_v) ? chk_idx : home_q;

  assign stat.cmd       = cmd_q;
  assign stat.quick_hit = is_rev && (quick_black || quick_white);
  assign stat.scan_done = scan_done;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rgb_q       <= in_data[25:2];
      pix_q       <= in_data[57:26];
      home_q      <= rphc_pkg::home_slot(in_data[25:2]);
      quick_black <= (in_data[57:26] == black_pixel);
      quick_white <= (in_data[57:26] == white_pixel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q     <= rphc_pkg::CMD_INIT;
      chk_vld   <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      if (ctrl.load) begin
        cmd_q <= rphc_pkg::cmd_t'(in_data[1:0]);
      end
      if (ctrl.scan_start) begin
        chk_vld   <= 1'b0;
        scan_done <= 1'b0;
      end else begin
        chk_vld <= issue;
        if (ctrl.scan_run && chk_vld && stop) begin
          scan_done <= 1'b1;
        end
      end
    end
  end

  // scan pipeline: issue one read per cycle, check the slot in the cycle after
  always_ff @(posedge clk) begin
    chk_idx <= rd_addr;
    if (ctrl.scan_start) begin
      rd_addr   <= is_rev ? '0 : home_q;
      issue_cnt <= '0;
      eval_cnt  <= '0;
    end else begin
      if (issue) begin
        rd_addr   <= (rd_addr == IDX_W'(SLOTS - 1)) ? '0 : rd_addr + 1'b1;
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (ctrl.scan_run && chk_vld) begin
        eval_cnt <= eval_cnt + 1'b1;
        if (stop) begin
          res_found <= match;
          res_idx   <= sel_idx;
          res_word  <= rd_word;
        end
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = res_idx;
    wr_data = {rgb_q, pix_q};
    if (ctrl.seed_black) begin
      wr_en   = 1'b1;
      wr_addr = rphc_pkg::BLACK_SLOT;
      wr_data = {rphc_pkg::RGB_BLACK,
                 ctrl.seed_reset ? rphc_pkg::RESET_BLACK_PIX : black_pixel};
    end else if (ctrl.seed_white) begin
      wr_en   = 1'b1;
      wr_addr = rphc_pkg::WHITE_SLOT;
      wr_data = {rphc_pkg::RGB_WHITE,
                 ctrl.seed_reset ? rphc_pkg::RESET_WHITE_PIX : white_pixel};
    end else if (ctrl.write_ins) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= rphc_pkg::VALID_SEED;
    end else if (ctrl.clear_valid) begin
      valid_bits <= rphc_pkg::VALID_SEED;
    end else if (ctrl.write_ins) begin
      valid_bits[res_idx] <= 1'b1;
    end
  end

  always_comb begin
    out_hit = 1'b0;
    out_pix = '0;
    out_rgb = '0;
    case (cmd_q)
      rphc_pkg::CMD_INIT: begin
        out_hit = 1'b0;
      end
      rphc_pkg::CMD_LOOKUP: begin
        out_hit = res_found;
        out_pix = res_found ? res_word[PIX_W-1:0] : '0;
      end
      rphc_pkg::CMD_INSERT: begin
        out_pix = pix_q;
      end
      rphc_pkg::CMD_REVERSE: begin
        if (quick_black) begin
          out_hit = 1'b1;
        end else if (quick_white) begin
          out_hit = 1'b1;
          out_rgb = rphc_pkg::RGB_WHITE;
        end else begin
          out_hit = res_found;
          out_rgb = res_found ? res_word[WORD_W-1:PIX_W] : '0;
        end
      end
      default: begin
        out_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data <= {7'd0, out_rgb, out_pix, out_hit};
    end
  end

endmodule
`default_nettype wire

>>> src/rgb_pixel_hash_cache.sv
// Colour cache: 64 slots mapping 0xRRGGBB colours to pixel values, linear probing.
// Input stream (s_*): one command per transfer - init, lookup, insert or
// reverse lookup. Output stream (m_*): exactly one result per command.
// APB port: black_pixel at 0x0, white_pixel at 0x4; write only while idle.
// Init clears the table and reseeds slots 0 and 63 from the registers; lookup
// and insert probe 1..64 slots from the home slot, insert then writing the
// chosen slot; reverse lookup answers a black or white pixel straight from the
// registers, else scans from slot 0 until a matching slot or the table end.
// The probe walks one slot per cycle through the single read port of the
// slot memory. A new command is taken only once the last result is loaded.
// Reset: states RST_BLACK and RST_WHITE seed slot 0 (black) and slot 63
// (white) with the reset register values; s_tready stays low meanwhile.
// A stalled result holds in the output register; the block still takes one
// new command and parks its result until the output register frees.
`default_nettype none
module rgb_pixel_hash_cache (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [1:0] command, [25:2] color_rgb, [57:26] pixel_in, [63:58] zero
  input  wire logic [rphc_pkg::TDATA_W-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] hit, [32:1] pixel_out, [56:33] rgb_out, [63:57] zero
  output logic [rphc_pkg::TDATA_W-1:0]       m_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rphc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [rphc_pkg::PIX_W-1:0] black_pixel;
  logic [rphc_pkg::PIX_W-1:0] white_pixel;
  rphc_pkg::ctrl_t ctrl;
  rphc_pkg::stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rphc_pkg::REG_WHITE) ? white_pixel : black_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_pixel <= rphc_pkg::RESET_BLACK_PIX;
      white_pixel <= rphc_pkg::RESET_WHITE_PIX;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == rphc_pkg::REG_WHITE) begin
        white_pixel <= pwdata;
      end else begin
        black_pixel <= pwdata;
      end
    end
  end

  rphc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  rphc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .in_data     (s_tdata),
    .black_pixel (black_pixel),
    .white_pixel (white_pixel),
    .stat        (stat),
    .out_data    (m_tdata)
  );

`include "rgb_pixel_hash_cache_assert.svh"

  // one command in flight: no accept right after an accept
  `RPHC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  // no command reports both a pixel and a colour
  `RPHC_ASSERT_NOW(a_one_payload, m_tvalid, m_tdata[32:1] == 32'd0 || m_tdata[56:33] == 24'd0)
  // result register loads only from the done state with a free output
  `RPHC_ASSERT_NOW(a_load_free, ctrl.out_load, !m_tvalid || m_tready)
  // a slot write never overlaps a running probe
  `RPHC_ASSERT_NOW(a_no_write_in_scan, ctrl.scan_run, !(ctrl.write_ins || ctrl.seed_black || ctrl.seed_white))

endmodule
`default_nettype wire

>>> verif/rphc_scoreboard.sv
`timescale 1ns / 1ps
module rphc_scoreboard
  import rphc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  input  wire logic               s_tready,
  // [1:0] command, [25:2] color_rgb, [57:26] pixel_in, [63:58] zero
  input  wire logic [TDATA_W-1:0] s_tdata,
  input  wire logic               m_tvalid,
  input  wire logic               m_tready,
  // [0] hit, [32:1] pixel_out, [56:33] rgb_out, [63:57] zero
  input  wire logic [TDATA_W-1:0] m_tdata,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic [31:0]        prdata,
  input  wire logic               pready,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic             hit;
    logic [PIX_W-1:0] pixel;
    logic [RGB_W-1:0] rgb;
  } cache_result_t;

  logic [PIX_W-1:0] black_pix;
  logic [PIX_W-1:0] white_pix;
  logic             slot_used [SLOTS];
  logic [RGB_W-1:0] slot_rgb  [SLOTS];
  logic [PIX_W-1:0] slot_pix  [SLOTS];

  cache_result_t    result_q [$];
  cache_result_t    want;
  cache_result_t    got;
  logic [31:0]      want_reg;
  int               errors = 0;

  assign fail_count = errors;

  function automatic void seed_slots();
    int k;
    for (k = 0; k < SLOTS; k++) begin
      slot_used[k] = 1'b0;
      slot_rgb[k]  = '0;
      slot_pix[k]  = '0;
    end
    slot_used[0]         = 1'b1;
    slot_pix[0]          = black_pix;
    slot_used[SLOTS-1]   = 1'b1;
    slot_rgb[SLOTS-1]    = RGB_WHITE;
    slot_pix[SLOTS-1]    = white_pix;
  endfunction

  // Walk up from the home slot; stop on an empty slot, a matching colour, or a
  // full wrap, in which case the home slot is returned.
  function automatic int probe_from_home(input logic [RGB_W-1:0] rgb, output bit found);
    int start;
    int pos;
    int steps;
    start = int'({rgb[23:22], rgb[15:14], rgb[7:6]});
    pos   = start;
    found = 1'b0;
    for (steps = 0; steps < SLOTS; steps++) begin
      if (!slot_used[pos]) return pos;
      if (slot_rgb[pos] == rgb) begin
        found = 1'b1;
        return pos;
      end
      pos = (pos + 1) % SLOTS;
    end
    return start;
  endfunction

  function automatic cache_result_t run_command(input cmd_t cmd, input logic [RGB_W-1:0] rgb,
                                                input logic [PIX_W-1:0] pix);
    cache_result_t res;
    int            slot;
    bit            found;
    res = '0;
    case (cmd)
      CMD_INIT: seed_slots();
      CMD_LOOKUP: begin
        slot = probe_from_home(rgb, found);
        if (found) begin
          res.hit   = 1'b1;
          res.pixel = slot_pix[slot];
        end
      end
      CMD_INSERT: begin
        slot = probe_from_home(rgb, found);
        slot_used[slot] = 1'b1;
        slot_rgb[slot]  = rgb;
        slot_pix[slot]  = pix;
        res.pixel       = pix;
      end
      default: begin
        // black register wins over white, both over the table
        if (pix == black_pix) begin
          res.hit = 1'b1;
        end else if (pix == white_pix) begin
          res.hit = 1'b1;
          res.rgb = RGB_WHITE;
        end else begin
          for (slot = 0; slot < SLOTS && !res.hit; slot++) begin
            if (slot_used[slot] && slot_pix[slot] == pix) begin
              res.hit = 1'b1;
              res.rgb = slot_rgb[slot];
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      black_pix = RESET_BLACK_PIX;
      white_pix = RESET_WHITE_PIX;
      seed_slots();
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WHITE) white_pix = pwdata;
        else black_pix = pwdata;
      end
      if (psel && penable && !pwrite && pready) begin
        want_reg = (paddr[2] == REG_WHITE) ? white_pix : black_pix;
        if (prdata !== want_reg) begin
          $display("%0t: register read at %0h expected %h got %h",
                   $time, paddr, want_reg, prdata);
          errors++;
        end
      end
      // retire before accepting, so a fresh command cannot cover a stray result
      if (m_tvalid && m_tready) begin
        got.hit   = m_tdata[0];
        got.pixel = m_tdata[32:1];
        got.rgb   = m_tdata[56:33];
        if (result_q.size() == 0) begin
          $display("%0t: result transfer with nothing pending, expected none got %h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b got %0b", $time, want.hit, got.hit);
            errors++;
          end
          if (got.pixel !== want.pixel) begin
            $display("%0t: pixel_out expected %h got %h", $time, want.pixel, got.pixel);
            errors++;
          end
          if (got.rgb !== want.rgb) begin
            $display("%0t: rgb_out expected %h got %h", $time, want.rgb, got.rgb);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        result_q.push_back(run_command(cmd_t'(s_tdata[1:0]), s_tdata[25:2], s_tdata[57:26]));
    end
    pending <= result_q.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rphc_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 108;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [ADDR_W-1:0]  paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  int                 fail_count;
  int                 pending;
  int                 cycles = 0;

  logic [RGB_W-1:0]   color_pool [32];
  logic [PIX_W-1:0]   pixel_pool [16];
  logic [PIX_W-1:0]   black_val = RESET_BLACK_PIX;
  logic [PIX_W-1:0]   white_val = RESET_WHITE_PIX;
  int                 burst_left = 1;

  logic [15:0]        stall_pat = '0;
  logic [3:0]         stall_pos = '0;

  rgb_pixel_hash_cache u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rphc_scoreboard u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: a 16-bit ready pattern, stepped bit by bit and redrawn each time it runs out
  always @(posedge clk) begin
    stall_pos <= stall_pos + 4'd1;
    if (stall_pos == 4'd15) begin
      case ($urandom_range(0, 3))
        0: stall_pat <= 16'hFFFF;
        1: stall_pat <= 16'($urandom);
        2: stall_pat <= 16'($urandom | $urandom);
        default: stall_pat <= 16'h0001;
      endcase
    end
    m_tready <= stall_pat[stall_pos];
  end

  task automatic send_cmd(input cmd_t cmd, input logic [RGB_W-1:0] rgb,
                          input logic [PIX_W-1:0] pix);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, pix, rgb, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_INSERT) begin
      color_pool[$urandom_range(0, 31)] = rgb;
      pixel_pool[$urandom_range(0, 15)] = pix;
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      gap = $urandom_range(0, 20);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Pick a colour: reuse a known one, crowd a home slot (mostly near the wrap), or draw fresh
  function automatic logic [RGB_W-1:0] pick_color(input int reuse_pct);
    logic [RGB_W-1:0] c;
    logic [5:0]       home;
    int               r;
    r = $urandom_range(0, 99);
    c = RGB_W'($urandom);
    if (r < reuse_pct) begin
      c = color_pool[$urandom_range(0, 31)];
    end else if (r < reuse_pct + 30) begin
      case ($urandom_range(0, 4))
        0: home = 6'd0;
        1: home = 6'd1;
        2: home = 6'd62;
        3: home = 6'd63;
        default: home = 6'($urandom);
      endcase
      c[23:22] = home[5:4];
      c[15:14] = home[3:2];
      c[7:6]   = home[1:0];
    end
    return c;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2: return pixel_pool[$urandom_range(0, 15)];
      3:       return black_val;
      4:       return white_val;
      5:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int init_pct, input int insert_pct, input int reuse_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < init_pct)
      send_cmd(CMD_INIT, RGB_W'($urandom), $urandom);
    else if (r < init_pct + insert_pct)
      send_cmd(CMD_INSERT, pick_color(reuse_pct), pick_pixel());
    else if (r < init_pct + insert_pct + (100 - init_pct - insert_pct) / 2)
      send_cmd(CMD_LOOKUP, pick_color(40), $urandom);
    else
      send_cmd(CMD_REVERSE, RGB_W'($urandom), pick_pixel());
  endtask

  task automatic reg_access(input logic write_en, input logic regsel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {regsel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (write_en) begin
      if (regsel == REG_WHITE) white_val = value;
      else black_val = value;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int               phase;
    int               n;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] w;

    for (n = 0; n < 32; n++) color_pool[n] = RGB_W'($urandom);
    for (n = 0; n < 16; n++) pixel_pool[n] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reg_access(1'b0, REG_BLACK, 32'h0);
    reg_access(1'b0, REG_WHITE, 32'h0);

    // seeded entries, then collisions around slot 0 and a wrap from slot 63
    send_cmd(CMD_LOOKUP,  24'h000000, 32'hFFFF_FFFF);
    send_cmd(CMD_LOOKUP,  24'hFFFFFF, 32'h0);
    send_cmd(CMD_REVERSE, 24'hFFFFFF, 32'h0000_0000);
    send_cmd(CMD_REVERSE, 24'h000000, 32'h00FF_FFFF);
    send_cmd(CMD_INSERT,  24'hFFFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_LOOKUP,  24'hFFFFFF, 32'h0);
    send_cmd(CMD_INSERT,  24'h3F3F3F, 32'h1234_5678);
    send_cmd(CMD_INSERT,  24'hC0C0C0, 32'hDEAD_BEEF);
    send_cmd(CMD_LOOKUP,  24'hC0C0C0, 32'h0);
    send_cmd(CMD_LOOKUP,  24'hC1C1C1, 32'h0);
    send_cmd(CMD_REVERSE, 24'h0,      32'hDEAD_BEEF);
    send_cmd(CMD_REVERSE, 24'h0,      32'h1234_5678);
    send_cmd(CMD_REVERSE, 24'h0,      32'hFFFF_FFFF);
    send_cmd(CMD_REVERSE, 24'h0,      32'h5555_5555);
    send_cmd(CMD_INSERT,  24'h123456, 32'h0);
    send_cmd(CMD_REVERSE, 24'hFFFFFF, 32'h0);
    send_cmd(CMD_INSERT,  24'h3F3F3F, 32'hAAAA_AAAA);
    send_cmd(CMD_LOOKUP,  24'h3F3F3F, 32'h0);
    send_cmd(CMD_INIT,    24'hFFFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_LOOKUP,  24'hC0C0C0, 32'h0);

    for (phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: begin b = 32'hFFFF_FFFF; w = 32'h0; end
        1: begin b = $urandom; w = b; end
        3: begin b = 32'h0; w = 32'hFFFF_FFFF; end
        default: begin b = $urandom; w = $urandom; end
      endcase
      reg_access(1'b1, REG_BLACK, b);
      reg_access(1'b1, REG_WHITE, w);
      reg_access(1'b0, REG_BLACK, 32'h0);
      reg_access(1'b0, REG_WHITE, 32'h0);
      // keep the stale seeds in one phase to show the registers act at once on reverse
      if (phase != 1) send_cmd(CMD_INIT, RGB_W'($urandom), $urandom);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2) send_random(0, 85, 15);
        else send_random(2, 35, 40);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
